@@ rtl/prf_pkg.sv @@
// prf_pkg: shared types and codes for the push-relabel max flow block
// used by the engine, the top level, the checkers and the testbench; no dependencies
package prf_pkg;

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_COMPUTE = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  localparam logic [1:0] REG_SOURCE = 2'd0;
  localparam logic [1:0] REG_SINK   = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  localparam int FLOW_OUT_W = 21;
  localparam int EXCESS_MIN_W = 22;
  localparam logic [21:0] EXCESS_INIT = 22'h3FFFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  from_node;
    logic [4:0]  to_node;
    logic [15:0] edge_capacity;
  } in_item_t;

  typedef struct packed {
    logic [20:0] max_flow;
  } out_item_t;

  typedef struct packed {
    logic [1:0] reg_index;
    logic [5:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic [4:0] source_node;
    logic [4:0] sink_node;
    logic [5:0] node_count;
  } cfg_regs_t;

  typedef struct packed {
    logic        idle;
    logic        done;
    logic [20:0] flow;
  } eng_stat_t;

endpackage

@@ rtl/prf_chan_if.sv @@
// prf_chan_if: valid/ready channel carrying one payload struct per beat
// payload types come from prf_pkg
interface prf_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/prf_alu.sv @@
// prf_alu: shared residual / push-amount / excess arithmetic unit
// used by prf_engine for pushes and relabel scans; no package dependencies
module prf_alu #(
  parameter int CW  = 16,
  parameter int HW  = 7,
  parameter int EXW = 22
) (
  input  logic [CW-1:0]        cap,
  input  logic signed [CW:0]   flow,
  input  logic [EXW-1:0]       eu,
  input  logic [EXW-1:0]       ev,
  input  logic [HW-1:0]        hu,
  input  logic [HW-1:0]        hv,
  input  logic                 sat,
  output logic                 res_pos,
  output logic                 push_ok,
  output logic                 q_push,
  output logic signed [CW:0]   flow_new,
  output logic [EXW-1:0]       eu_new,
  output logic [EXW-1:0]       ev_new
);
  logic signed [CW+1:0] res;
  logic [CW:0]          amt;
  logic signed [CW+1:0] fsum;

  always_comb begin
    res      = $signed({2'b00, cap}) - $signed({flow[CW], flow});
    res_pos  = !res[CW+1] && (res != '0);
    amt      = (EXW'(res[CW:0]) < eu) ? res[CW:0] : eu[CW:0];
    fsum     = $signed({flow[CW], flow}) + $signed({1'b0, amt});
    flow_new = fsum[CW:0];
    eu_new   = eu - EXW'(amt);
    ev_new   = ev + EXW'(amt);
    push_ok  = res_pos && (sat || (hu > hv));
    q_push   = push_ok && (amt != '0) && (ev == '0);
  end
endmodule

@@ rtl/prf_fifo.sv @@
// prf_fifo: active node queue, one write and one registered read per cycle
// no package dependencies
module prf_fifo #(
  parameter int DEPTH = 32,
  parameter int DW    = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty   = (cnt_r == '0);
  assign do_push = push && (cnt_r < (AW+1)'(DEPTH));
  assign do_pop  = pop && !empty;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (clr) begin
      head_nxt = '0;
      tail_nxt = '0;
      cnt_nxt  = '0;
    end else begin
      if (do_push) tail_nxt = wrap_inc(tail_r);
      if (do_pop) head_nxt = wrap_inc(head_r);
      cnt_nxt = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push && !clr) mem[tail_r] <= push_data;
    pop_data <= mem[head_r];
  end
endmodule

@@ rtl/prf_engine.sv @@
// prf_engine: sequencer, capacity/flow/node memories and the flow run
// depends on prf_pkg, prf_alu and prf_fifo
module prf_engine #(
  parameter int MAX_NODES = 32,
  parameter int CAP_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_acc,
  input  prf_pkg::in_item_t  in_item,
  input  prf_pkg::cfg_regs_t cfg,
  input  logic               res_ack,
  output prf_pkg::eng_stat_t stat
);
  localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int AW  = 2 * NW;
  localparam int SW  = AW + 1;
  localparam int CW  = CAP_WIDTH;
  localparam int HW  = NW + 2;
  localparam int EXW = (CW + NW + 2 > prf_pkg::EXCESS_MIN_W) ? CW + NW + 2
                                                            : prf_pkg::EXCESS_MIN_W;
  localparam int TW  = EXW;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001, S_CLR  = 16'h0002, S_INIT = 16'h0004, S_CHK  = 16'h0008,
    S_RD    = 16'h0010, S_EVAL = 16'h0020, S_MIRR = 16'h0040, S_LRD  = 16'h0080,
    S_LEVAL = 16'h0100, S_WB   = 16'h0200, S_POP  = 16'h0400, S_POPD = 16'h0800,
    S_LOAD  = 16'h1000, S_SRD  = 16'h2000, S_SADD = 16'h4000, S_DONE = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic [SW-1:0]  sweep_r, sweep_nxt;
  logic [NW:0]    n_r, n_nxt, cur_r, cur_nxt;
  logic [NW-1:0]  s_r, s_nxt, t_r, t_nxt, u_r, u_nxt;
  logic [HW-1:0]  hu_r, hu_nxt, low_r, low_nxt;
  logic [EXW-1:0] eu_r, eu_nxt;
  logic           sat_r, sat_nxt, found_r, found_nxt;
  logic signed [CW:0] nflow_r, nflow_nxt;
  logic signed [TW-1:0] total_r, total_nxt;
  logic [prf_pkg::FLOW_OUT_W-1:0] result_r, result_nxt;

  logic [CW-1:0]      cap_mem  [2**AW];
  logic signed [CW:0] flow_mem [2**AW];
  logic [HW-1:0]      h_mem [MAX_NODES];
  logic [EXW-1:0]     e_mem [MAX_NODES];
  logic [NW:0]        c_mem [MAX_NODES];
  logic [CW-1:0]      cap_q;
  logic signed [CW:0] flow_q;
  logic [HW-1:0]      h_q;
  logic [EXW-1:0]     e_q;
  logic [NW:0]        c_q;

  logic               cap_we, flow_we, h_we, e_we, c_we;
  logic [AW-1:0]      cap_waddr, flow_waddr, edge_raddr;
  logic [CW-1:0]      cap_wdata;
  logic signed [CW:0] flow_wdata;
  logic [NW-1:0]      nd_raddr, nd_waddr;
  logic [HW-1:0]      h_wdata;
  logic [EXW-1:0]     e_wdata;
  logic [NW:0]        c_wdata;

  logic               q_clr, q_push, q_pop, q_empty;
  logic [NW-1:0]      q_pdata, q_rdata;

  logic               a_res_pos, a_push_ok, a_qpush;
  logic signed [CW:0] a_flow_new;
  logic [EXW-1:0]     a_eu_new, a_ev_new;
  logic [NW:0]        n_cfg;
  logic [NW-1:0]      cur_i;

  prf_alu #(.CW(CW), .HW(HW), .EXW(EXW)) u_alu (
    .cap(cap_q), .flow(flow_q), .eu(eu_r), .ev(e_q), .hu(hu_r), .hv(h_q),
    .sat(sat_r), .res_pos(a_res_pos), .push_ok(a_push_ok), .q_push(a_qpush),
    .flow_new(a_flow_new), .eu_new(a_eu_new), .ev_new(a_ev_new)
  );

  prf_fifo #(.DEPTH(MAX_NODES), .DW(NW)) u_fifo (
    .clk(clk), .rst_n(rst_n), .clr(q_clr), .push(q_push), .push_data(q_pdata),
    .pop(q_pop), .pop_data(q_rdata), .empty(q_empty)
  );

  assign cur_i = cur_r[NW-1:0];
  assign n_cfg = (32'(cfg.node_count) > 32'(MAX_NODES)) ? (NW+1)'(MAX_NODES)
                                                       : (NW+1)'(cfg.node_count);

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE);
  assign stat.flow = result_r;

  always_comb begin
    state_nxt = state_r;  sweep_nxt = sweep_r; n_nxt = n_r;   cur_nxt = cur_r;
    s_nxt = s_r;          t_nxt = t_r;         u_nxt = u_r;   hu_nxt = hu_r;
    low_nxt = low_r;      eu_nxt = eu_r;       sat_nxt = sat_r;
    found_nxt = found_r;  nflow_nxt = nflow_r; total_nxt = total_r;
    result_nxt = result_r;
    cap_we = 1'b0;  cap_waddr = '0; cap_wdata = '0;
    flow_we = 1'b0; flow_waddr = '0; flow_wdata = '0;
    edge_raddr = '0; nd_raddr = '0; nd_waddr = '0;
    h_we = 1'b0; h_wdata = '0; e_we = 1'b0; e_wdata = '0; c_we = 1'b0; c_wdata = '0;
    q_clr = 1'b0; q_push = 1'b0; q_pdata = '0; q_pop = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          priority case (in_item.req_type)
            prf_pkg::REQ_WRITE: begin
              if (32'(in_item.from_node) < 32'(MAX_NODES) &&
                  32'(in_item.to_node) < 32'(MAX_NODES)) begin
                cap_we    = 1'b1;
                cap_waddr = {NW'(in_item.from_node), NW'(in_item.to_node)};
                cap_wdata = CW'(in_item.edge_capacity);
              end
            end
            prf_pkg::REQ_CLEAR: begin
              sweep_nxt = '0;
              state_nxt = S_CLR;
            end
            prf_pkg::REQ_COMPUTE: begin
              if (n_cfg < (NW+1)'(2) || 32'(cfg.source_node) >= 32'(n_cfg) ||
                  32'(cfg.sink_node) >= 32'(n_cfg) ||
                  cfg.source_node == cfg.sink_node) begin
                result_nxt = '0;
                state_nxt  = S_DONE;
              end else begin
                n_nxt     = n_cfg;
                s_nxt     = NW'(cfg.source_node);
                t_nxt     = NW'(cfg.sink_node);
                sweep_nxt = '0;
                state_nxt = S_INIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        cap_we    = 1'b1;
        cap_waddr = sweep_r[AW-1:0];
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == SW'(2**AW - 1)) state_nxt = S_IDLE;
      end
      S_INIT: begin
        flow_we    = 1'b1;
        flow_waddr = sweep_r[AW-1:0];
        if (sweep_r < SW'(MAX_NODES)) begin
          nd_waddr = sweep_r[NW-1:0];
          h_we = 1'b1; e_we = 1'b1; c_we = 1'b1;
          h_wdata = (sweep_r[NW-1:0] == s_r) ? HW'(n_r) : '0;
        end
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == SW'(2**AW - 1)) begin
          q_clr   = 1'b1;
          u_nxt   = s_r;
          hu_nxt  = HW'(n_r);
          eu_nxt  = EXW'(prf_pkg::EXCESS_INIT);
          cur_nxt = '0;
          sat_nxt = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sat_r) begin
          if (cur_r == n_r) begin
            e_we = 1'b1; nd_waddr = s_r; e_wdata = eu_r;
            state_nxt = S_POP;
          end else if (cur_i == s_r) begin
            cur_nxt = cur_r + 1'b1;
          end else begin
            state_nxt = S_RD;
          end
        end else if (eu_r == '0) begin
          state_nxt = S_WB;
        end else if (cur_r < n_r) begin
          state_nxt = S_RD;
        end else begin
          cur_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_LRD;
        end
      end
      S_RD: begin
        edge_raddr = {u_r, cur_i};
        nd_raddr   = cur_i;
        state_nxt  = S_EVAL;
      end
      S_EVAL: begin
        // a self loop never carries flow
        if (a_push_ok && (cur_i != u_r)) begin
          flow_we    = 1'b1;
          flow_waddr = {u_r, cur_i};
          flow_wdata = a_flow_new;
          nflow_nxt  = a_flow_new;
          e_we = 1'b1; nd_waddr = cur_i; e_wdata = a_ev_new;
          eu_nxt  = a_eu_new;
          q_push  = a_qpush;
          q_pdata = cur_i;
          state_nxt = S_MIRR;
        end else begin
          cur_nxt   = cur_r + 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_MIRR: begin
        // reverse edge always carries the negated flow
        flow_we    = 1'b1;
        flow_waddr = {cur_i, u_r};
        flow_wdata = -nflow_r;
        if (sat_r) cur_nxt = cur_r + 1'b1;
        state_nxt = S_CHK;
      end
      S_LRD: begin
        if (cur_r == n_r) begin
          if (found_r) begin
            hu_nxt    = low_r + 1'b1;
            cur_nxt   = '0;
            state_nxt = S_CHK;
          end else begin
            state_nxt = S_WB;
          end
        end else begin
          edge_raddr = {u_r, cur_i};
          nd_raddr   = cur_i;
          state_nxt  = S_LEVAL;
        end
      end
      S_LEVAL: begin
        if (cur_i != u_r && a_res_pos && (!found_r || h_q < low_r)) begin
          low_nxt   = h_q;
          found_nxt = 1'b1;
        end
        cur_nxt   = cur_r + 1'b1;
        state_nxt = S_LRD;
      end
      S_WB: begin
        nd_waddr = u_r;
        h_we = 1'b1; h_wdata = hu_r;
        e_we = 1'b1; e_wdata = eu_r;
        c_we = 1'b1; c_wdata = cur_r;
        state_nxt = S_POP;
      end
      S_POP: begin
        if (q_empty) begin
          cur_nxt   = '0;
          total_nxt = '0;
          state_nxt = S_SRD;
        end else begin
          q_pop     = 1'b1;
          state_nxt = S_POPD;
        end
      end
      S_POPD: begin
        u_nxt = q_rdata;
        if (q_rdata == s_r || q_rdata == t_r) begin
          state_nxt = S_POP;
        end else begin
          nd_raddr  = q_rdata;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        hu_nxt  = h_q;
        eu_nxt  = e_q;
        cur_nxt = c_q;
        sat_nxt = 1'b0;
        state_nxt = S_CHK;
      end
      S_SRD: begin
        if (cur_r == n_r) begin
          result_nxt = total_r[TW-1] ? '0 : total_r[prf_pkg::FLOW_OUT_W-1:0];
          state_nxt  = S_DONE;
        end else begin
          edge_raddr = {cur_i, t_r};
          state_nxt  = S_SADD;
        end
      end
      S_SADD: begin
        total_nxt = total_r + TW'(flow_q);
        cur_nxt   = cur_r + 1'b1;
        state_nxt = S_SRD;
      end
      S_DONE: begin
        if (res_ack) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      sweep_r <= '0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;     cur_r <= cur_nxt;   s_r <= s_nxt;       t_r <= t_nxt;
    u_r <= u_nxt;     hu_r <= hu_nxt;     low_r <= low_nxt;   eu_r <= eu_nxt;
    sat_r <= sat_nxt; found_r <= found_nxt; nflow_r <= nflow_nxt;
    total_r <= total_nxt; result_r <= result_nxt;
  end

  always_ff @(posedge clk) begin
    if (cap_we) cap_mem[cap_waddr] <= cap_wdata;
    if (flow_we) flow_mem[flow_waddr] <= flow_wdata;
    cap_q  <= cap_mem[edge_raddr];
    flow_q <= flow_mem[edge_raddr];
  end

  always_ff @(posedge clk) begin
    if (h_we) h_mem[nd_waddr] <= h_wdata;
    if (e_we) e_mem[nd_waddr] <= e_wdata;
    if (c_we) c_mem[nd_waddr] <= c_wdata;
    h_q <= h_mem[nd_raddr];
    e_q <= e_mem[nd_raddr];
    c_q <= c_mem[nd_raddr];
  end
endmodule

@@ rtl/push_relabel_max_flow.sv @@
// push_relabel_max_flow: fifo push-relabel max flow over a dense capacity matrix
// depends on prf_pkg, prf_chan_if and prf_engine
// capacity write beats: one per cycle while the engine is idle, no result; clear beats: zero the matrix
// compute beats: flow init over the edge matrix, then pushes, cursor steps and relabel scans,
// then a pass that sums sink inflow; one edge memory port
// reset: synchronous, active low; a clearing pass over the capacity matrix runs before in_ready
module push_relabel_max_flow #(
  parameter int MAX_NODES = 32,
  parameter int CAP_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  prf_chan_if.sink   in_ch,
  prf_chan_if.source out_ch,
  prf_chan_if.sink   cfg_ch
);
  prf_pkg::cfg_regs_t cfg_r;
  prf_pkg::eng_stat_t stat;
  logic               in_acc;
  logic               slot_free;
  logic               out_valid_r;
  logic [prf_pkg::FLOW_OUT_W-1:0] out_flow_r;

  // config is always writable; index beyond the list is dropped
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_node <= 5'd0;
      cfg_r.sink_node   <= 5'd1;
      cfg_r.node_count  <= 6'd32;
    end else if (cfg_ch.valid) begin
      priority case (cfg_ch.data.reg_index)
        prf_pkg::REG_SOURCE: cfg_r.source_node <= cfg_ch.data.wdata[4:0];
        prf_pkg::REG_SINK:   cfg_r.sink_node   <= cfg_ch.data.wdata[4:0];
        prf_pkg::REG_COUNT:  cfg_r.node_count  <= cfg_ch.data.wdata;
        default: ;
      endcase
    end
  end

  // input beats land only while the engine sits idle
  assign in_ch.ready = stat.idle;
  assign in_acc      = in_ch.valid && stat.idle;

  // result slot frees up when empty or being taken this cycle
  assign slot_free = !out_valid_r || out_ch.ready;

  prf_engine #(.MAX_NODES(MAX_NODES), .CAP_WIDTH(CAP_WIDTH)) u_engine (
    .clk(clk), .rst_n(rst_n), .in_acc(in_acc), .in_item(in_ch.data),
    .cfg(cfg_r), .res_ack(slot_free), .stat(stat)
  );

  // output register decouples result beats from new input beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && slot_free) out_flow_r <= stat.flow;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.data.max_flow = out_flow_r;
endmodule

@@ rtl/prf_checker.sv @@
// prf_checker: port-level assertions for push_relabel_max_flow
// depends on prf_pkg; attached to the top level by bind
module prf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_req,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] out_flow
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_flow))
    else $error("result beat dropped or changed while stalled");

  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during clearing pass");

  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req == prf_pkg::REQ_COMPUTE |=> !in_ready)
    else $error("input ready right after compute beat");

  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req == prf_pkg::REQ_WRITE && !out_valid
    |=> !out_valid && in_ready)
    else $error("capacity write beat produced a result or stalled");
endmodule

bind push_relabel_max_flow prf_checker u_prf_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_req(in_ch.data.req_type), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_flow(out_ch.data.max_flow)
);

@@ sim/tb_flow_checker.sv @@
// tb_flow_checker: watches the request, config and result channels and predicts max flow
// depends on prf_pkg for the beat payload types and the request and register codes
`timescale 1ns / 100ps

module tb_flow_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  prf_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  prf_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  prf_pkg::cfg_item_t cfg_data,
  output int                 fail_count,
  output int                 flows_pending
);

  localparam int NODES = 32;

  logic [15:0]  cap_mx [NODES][NODES];
  longint       net_flow [NODES][NODES];
  int           level [NODES];
  longint       surplus [NODES];
  int           cursor [NODES];
  int           active_nodes [$];
  logic [4:0]   src_sel;
  logic [4:0]   snk_sel;
  logic [5:0]   cnt_sel;
  logic [20:0]  expected_flows [$];

  function automatic longint room_left(int a, int b);
    return longint'(cap_mx[a][b]) - net_flow[a][b];
  endfunction

  function automatic void push_flow(int a, int b);
    longint amount;
    amount = surplus[a] < room_left(a, b) ? surplus[a] : room_left(a, b);
    net_flow[a][b] += amount;
    net_flow[b][a] -= amount;
    surplus[a] -= amount;
    surplus[b] += amount;
    if (amount > 0 && surplus[b] == amount && active_nodes.size() < NODES)
      active_nodes.push_back(b);
  endfunction

  // self loops are skipped; returns 0 when the node has no residual edge
  function automatic bit relabel(int u, int n);
    bit found;
    int lowest;
    found = 0;
    lowest = 0;
    for (int v = 0; v < n; v++) begin
      if (v != u && room_left(u, v) > 0 && (!found || level[v] < lowest)) begin
        lowest = level[v];
        found = 1;
      end
    end
    if (found)
      level[u] = lowest + 1;
    return found;
  endfunction

  function automatic void discharge(int u, int n);
    while (surplus[u] > 0) begin
      if (cursor[u] < n) begin
        if (room_left(u, cursor[u]) > 0 && level[u] > level[cursor[u]])
          push_flow(u, cursor[u]);
        else
          cursor[u]++;
      end else begin
        if (!relabel(u, n))
          return;
        cursor[u] = 0;
      end
    end
  endfunction

  function automatic logic [20:0] predict_max_flow();
    int n;
    int s;
    int t;
    int u;
    longint total;
    n = cnt_sel > NODES ? NODES : int'(cnt_sel);
    s = src_sel;
    t = snk_sel;
    total = 0;
    if (n < 2 || s >= n || t >= n || s == t)
      return '0;
    for (int i = 0; i < NODES; i++) begin
      for (int j = 0; j < NODES; j++)
        net_flow[i][j] = 0;
      level[i] = 0;
      surplus[i] = 0;
      cursor[i] = 0;
    end
    active_nodes.delete();
    level[s] = n;
    surplus[s] = longint'(prf_pkg::EXCESS_INIT);
    for (int i = 0; i < n; i++)
      if (i != s)
        push_flow(s, i);
    while (active_nodes.size() > 0) begin
      u = active_nodes.pop_front();
      if (u != s && u != t)
        discharge(u, n);
    end
    for (int i = 0; i < n; i++)
      total += net_flow[i][t];
    if (total < 0)
      total = 0;
    return total[20:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      src_sel <= 5'd0;
      snk_sel <= 5'd1;
      cnt_sel <= 6'd32;
      for (int i = 0; i < NODES; i++)
        for (int j = 0; j < NODES; j++)
          cap_mx[i][j] = '0;
      expected_flows.delete();
      fail_count <= 0;
      flows_pending <= 0;
    end else begin
      // results first: a compute beat taken this edge cannot answer at the same edge
      if (out_valid && out_ready) begin
        if (expected_flows.size() == 0) begin
          $error("max_flow beat with nothing expected, actual %0d", out_data.max_flow);
          fail_count <= fail_count + 1;
        end else begin
          if (out_data.max_flow !== expected_flows[0]) begin
            $error("max_flow expected %0d actual %0d", expected_flows[0], out_data.max_flow);
            fail_count <= fail_count + 1;
          end
          void'(expected_flows.pop_front());
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.reg_index)
          prf_pkg::REG_SOURCE: src_sel <= cfg_data.wdata[4:0];
          prf_pkg::REG_SINK:   snk_sel <= cfg_data.wdata[4:0];
          prf_pkg::REG_COUNT:  cnt_sel <= cfg_data.wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_data.req_type)
          prf_pkg::REQ_WRITE:
            cap_mx[in_data.from_node][in_data.to_node] = in_data.edge_capacity;
          prf_pkg::REQ_CLEAR: begin
            for (int i = 0; i < NODES; i++)
              for (int j = 0; j < NODES; j++)
                cap_mx[i][j] = '0;
          end
          prf_pkg::REQ_COMPUTE: expected_flows.push_back(predict_max_flow());
          default: ;
        endcase
      end
      flows_pending <= expected_flows.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
// tb_top: stimulus, handshake idling, watchdog and verdict for push_relabel_max_flow
// depends on prf_pkg, prf_chan_if, the block and tb_flow_checker
`timescale 1ns / 100ps

module tb_top;

  // request code that the block must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int ITEM_GOAL     = 1250;
  localparam int SETTLE_CYCLES = 1100;     // covers a trailing clear pass over the 32x32 matrix
  localparam int HOLD_CYCLES   = 4000;     // long receiver stall for the back-pressure phase
  localparam int STALL_LIMIT   = 1500000;  // cycles with no beat anywhere before giving up

  logic clk;
  logic rst_n;

  prf_chan_if #(.payload_t(prf_pkg::in_item_t))  in_ch ();
  prf_chan_if #(.payload_t(prf_pkg::out_item_t)) out_ch ();
  prf_chan_if #(.payload_t(prf_pkg::cfg_item_t)) cfg_ch ();

  int fail_count;
  int flows_pending;

  // idling mode: 0 sender idles 16% and receiver 71%, 1 swapped, 2 no idling
  int  idle_mode;
  bit  hold_req;
  int  beats_sent;
  int  computes_sent;
  int  cfg_writes;
  int  stall_cycles;

  push_relabel_max_flow dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  tb_flow_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_data       (in_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_data      (out_ch.data),
    .cfg_valid     (cfg_ch.valid),
    .cfg_ready     (cfg_ch.ready),
    .cfg_data      (cfg_ch.data),
    .fail_count    (fail_count),
    .flows_pending (flows_pending)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result receiver: random ready per idling mode, plus one long hold-off on request
  initial begin : result_receiver
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else if (idle_mode == 0) begin
        out_ch.ready = ($urandom_range(0, 99) >= 71);
      end else if (idle_mode == 1) begin
        out_ch.ready = ($urandom_range(0, 99) >= 16);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // watchdog: counts cycles in which no beat moves on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, flows_pending);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // one request beat; entered and left at a falling edge
  task automatic send_req(logic [1:0] kind, int a, int b, int cap);
    int gap_pct;
    gap_pct = (idle_mode == 0) ? 16 : (idle_mode == 1) ? 71 : 0;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data.req_type = kind;
    in_ch.data.from_node = a[4:0];
    in_ch.data.to_node = b[4:0];
    in_ch.data.edge_capacity = cap[15:0];
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
    if (kind != REQ_UNUSED)
      beats_sent++;
    if (kind == prf_pkg::REQ_COMPUTE)
      computes_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    cfg_ch.valid = 1'b1;
    cfg_ch.data.reg_index = idx;
    cfg_ch.data.wdata = value[5:0];
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    cfg_writes++;
  endtask

  // registers change only with nothing in flight and any clear pass finished
  task automatic set_graph(int src, int snk, int cnt);
    while (flows_pending != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(prf_pkg::REG_SOURCE, src);
    write_reg(prf_pkg::REG_SINK, snk);
    write_reg(prf_pkg::REG_COUNT, cnt);
  endtask

  function automatic int pick_capacity();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5)
      return $urandom_range(0, 20);
    else if (r < 8)
      return $urandom_range(0, 65535);
    else if (r == 8)
      return 65535;
    return 0;
  endfunction

  // random edges mostly inside the active nodes, with some noise beats mixed in
  task automatic load_random_edges(int n, int edges);
    int a;
    int b;
    for (int k = 0; k < edges; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom_range(0, 31);
        b = $urandom_range(0, 31);
      end else begin
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
      end
      send_req(prf_pkg::REQ_WRITE, a, b, pick_capacity());
      if ($urandom_range(0, 19) == 0)
        send_req(REQ_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(0, 65535));
    end
  endtask

  initial begin : stimulus
    int n;
    int src;
    int snk;
    int cnt;
    int r;
    bit dense_done;
    bit clamp_done;
    bit pressure_done;
    rst_n = 1'b0;
    idle_mode = 0;
    hold_req = 0;
    beats_sent = 0;
    computes_sent = 0;
    cfg_writes = 0;
    dense_done = 0;
    clamp_done = 0;
    pressure_done = 0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset config (source 0, sink 1, 32 nodes), field extremes, self loops,
    // overwrite, ignored request type, clear
    send_req(prf_pkg::REQ_WRITE, 0, 1, 65535);
    send_req(prf_pkg::REQ_WRITE, 31, 31, 65535);
    send_req(prf_pkg::REQ_WRITE, 0, 0, 1);
    send_req(REQ_UNUSED, 31, 31, 65535);
    send_req(prf_pkg::REQ_COMPUTE, 0, 0, 0);
    send_req(prf_pkg::REQ_WRITE, 0, 1, 5);
    send_req(prf_pkg::REQ_WRITE, 0, 2, 7);
    send_req(prf_pkg::REQ_WRITE, 2, 1, 3);
    send_req(prf_pkg::REQ_WRITE, 31, 1, 65535);
    send_req(prf_pkg::REQ_WRITE, 0, 31, 2);
    send_req(prf_pkg::REQ_COMPUTE, 31, 31, 65535);
    send_req(prf_pkg::REQ_CLEAR, 0, 0, 0);
    send_req(prf_pkg::REQ_COMPUTE, 0, 0, 0);
    send_req(prf_pkg::REQ_WRITE, 3, 4, 9);
    // degenerate graphs: source equals sink, too few nodes, endpoint out of range
    set_graph(3, 3, 8);
    send_req(prf_pkg::REQ_COMPUTE, 0, 0, 0);
    set_graph(0, 1, 0);
    send_req(prf_pkg::REQ_COMPUTE, 0, 0, 0);
    set_graph(0, 1, 1);
    send_req(prf_pkg::REQ_COMPUTE, 0, 0, 0);
    set_graph(3, 4, 4);
    send_req(prf_pkg::REQ_COMPUTE, 0, 0, 0);
    // node count above the matrix size clamps to 32
    set_graph(3, 4, 63);
    send_req(prf_pkg::REQ_COMPUTE, 0, 0, 0);

    // random graphs: clear, load, compute; idling mode steps with progress
    while (beats_sent < ITEM_GOAL) begin
      idle_mode = (beats_sent < ITEM_GOAL / 3) ? 0 : (beats_sent < 2 * ITEM_GOAL / 3) ? 1 : 2;
      if (!dense_done && beats_sent > ITEM_GOAL / 2) begin
        // every source edge and sink edge at full capacity: largest possible flow
        dense_done = 1;
        set_graph(0, 31, 32);
        send_req(prf_pkg::REQ_CLEAR, 0, 0, 0);
        for (int i = 1; i < 31; i++) begin
          send_req(prf_pkg::REQ_WRITE, 0, i, 65535);
          send_req(prf_pkg::REQ_WRITE, i, 31, 65535);
        end
        send_req(prf_pkg::REQ_WRITE, 0, 31, 65535);
        send_req(prf_pkg::REQ_COMPUTE, 0, 0, 0);
        continue;
      end
      if (!clamp_done && beats_sent > 3 * ITEM_GOAL / 4) begin
        // sparse graph over all 32 nodes with an oversized node count
        clamp_done = 1;
        set_graph($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(33, 63));
        send_req(prf_pkg::REQ_CLEAR, 0, 0, 0);
        load_random_edges(32, 40);
        send_req(prf_pkg::REQ_COMPUTE, 0, 0, 0);
        continue;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        cnt = $urandom_range(0, 9);
        src = $urandom_range(0, 31);
        snk = ($urandom_range(0, 1) == 1) ? src : $urandom_range(0, 31);
        n = 8;
      end else begin
        n = (r < 80) ? $urandom_range(2, 8) : $urandom_range(9, 12);
        cnt = n;
        src = $urandom_range(0, n - 1);
        snk = $urandom_range(0, n - 1);
        if (snk == src)
          snk = (src + 1) % n;
      end
      set_graph(src, snk, cnt);
      send_req(prf_pkg::REQ_CLEAR, 0, 0, 0);
      load_random_edges(n, $urandom_range(n, (4 * n > 30) ? 30 : 4 * n));
      send_req(prf_pkg::REQ_COMPUTE, 0, 0, 0);
      if (idle_mode == 2 && !pressure_done) begin
        // results pile up behind a stalled receiver until the request side backs up
        pressure_done = 1;
        hold_req = 1;
        repeat (8) begin
          send_req(prf_pkg::REQ_WRITE, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                   pick_capacity());
          send_req(prf_pkg::REQ_COMPUTE, 0, 0, 0);
        end
      end else if ($urandom_range(0, 3) == 0) begin
        // overwrite one edge and ask again on the same graph
        send_req(prf_pkg::REQ_WRITE, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                 pick_capacity());
        send_req(prf_pkg::REQ_COMPUTE, 0, 0, 0);
      end
    end

    while (flows_pending != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("run covered %0d request beats, %0d of them max flow computes, %0d register writes",
             beats_sent, computes_sent, cfg_writes);
    $display("graphs of 2 to 32 nodes, degenerate setups, clamped node count and a long result stall");
    if (fail_count == 0 && flows_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
